// ===== hw/rtl/rfhu_pkg.sv =====
`default_nettype none

package rfhu_pkg;

  // parser phase; the spare code falls back to header handling
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned PAIRS_BITS  = 8;
  localparam int unsigned COUNT_BITS  = 9;
  localparam int unsigned MODULE_BITS = 4;
  localparam int unsigned CABLE_BITS  = 4;
  localparam int unsigned ADDR_BITS   = 5;
  localparam int unsigned CHAN_BITS   = 5;
  localparam int unsigned CAL_BITS    = 4;
  localparam int unsigned CLOCK_BITS  = 6;
  localparam int unsigned TIME_BITS   = 12;
  localparam int unsigned CHARGE_BITS = 12;

  // hit fields that do not depend on the index width
  typedef struct packed {
    logic [MODULE_BITS-1:0] module_id;
    logic [CABLE_BITS-1:0]  cable_id;
    logic [ADDR_BITS-1:0]   converter_addr;
    logic [CHAN_BITS-1:0]   channel;
    logic [CAL_BITS-1:0]    cal_bits;
    logic [CLOCK_BITS-1:0]  clock_count;
    logic [TIME_BITS-1:0]   time_value;
    logic [CHARGE_BITS-1:0] charge_value;
  } hit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfhu_parser.sv =====
`default_nettype none

module rfhu_parser #(
  parameter int unsigned HIT_INDEX_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                word_take,
  input  wire logic [rfhu_pkg::WORD_BITS-1:0]      data_word,
  input  wire logic                                buffer_end,
  output      logic                                hit_valid,
  output      rfhu_pkg::hit_t                      hit,
  output      logic [HIT_INDEX_BITS-1:0]           hit_index
);

  rfhu_pkg::phase_t                        phase_r, phase_nxt;
  logic [rfhu_pkg::PAIRS_BITS-1:0]         pairs_left_r, pairs_left_nxt;
  logic [rfhu_pkg::MODULE_BITS-1:0]        frame_module_r, frame_module_nxt;
  logic [rfhu_pkg::CABLE_BITS-1:0]         frame_cable_r, frame_cable_nxt;
  logic [rfhu_pkg::WORD_BITS-1:0]          held_word_r;
  logic [HIT_INDEX_BITS-1:0]               hit_cnt_r, hit_cnt_nxt;
  logic [rfhu_pkg::COUNT_BITS-1:0]         word_count;
  logic [rfhu_pkg::COUNT_BITS-1:0]         count_less_one;

  assign word_count     = data_word[rfhu_pkg::COUNT_BITS-1:0];
  // pairs after the first one: ceil(count/2) - 1 == (count - 1) / 2
  assign count_less_one = word_count - rfhu_pkg::COUNT_BITS'(1);

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    pairs_left_nxt   = pairs_left_r;
    frame_module_nxt = frame_module_r;
    frame_cable_nxt  = frame_cable_r;
    hit_cnt_nxt      = hit_cnt_r;
    if (word_take) begin
      unique case (phase_r)
        rfhu_pkg::PH_FIRST: begin
          phase_nxt = rfhu_pkg::PH_SECOND;
        end
        rfhu_pkg::PH_SECOND: begin
          if (!(&hit_cnt_r)) begin
            hit_cnt_nxt = hit_cnt_r + HIT_INDEX_BITS'(1);
          end
          if (pairs_left_r == '0) begin
            phase_nxt = rfhu_pkg::PH_HEADER;
          end else begin
            pairs_left_nxt = pairs_left_r - rfhu_pkg::PAIRS_BITS'(1);
            phase_nxt      = rfhu_pkg::PH_FIRST;
          end
        end
        default: begin
          frame_module_nxt = data_word[31:28];
          frame_cable_nxt  = data_word[27:24];
          if (word_count == '0) begin
            phase_nxt      = rfhu_pkg::PH_HEADER;
            pairs_left_nxt = '0;
          end else begin
            pairs_left_nxt = count_less_one[rfhu_pkg::COUNT_BITS-1:1];
            phase_nxt      = rfhu_pkg::PH_FIRST;
          end
        end
      endcase
      if (buffer_end) begin
        phase_nxt      = rfhu_pkg::PH_HEADER;
        pairs_left_nxt = '0;
        hit_cnt_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rfhu_pkg::PH_HEADER;
      pairs_left_r   <= '0;
      frame_module_r <= '0;
      frame_cable_r  <= '0;
      hit_cnt_r      <= '0;
    end else begin
      phase_r        <= phase_nxt;
      pairs_left_r   <= pairs_left_nxt;
      frame_module_r <= frame_module_nxt;
      frame_cable_r  <= frame_cable_nxt;
      hit_cnt_r      <= hit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_take && phase_r == rfhu_pkg::PH_FIRST) begin
      held_word_r <= data_word;
    end
  end

  // outputs
  always_comb begin
    hit_valid = 1'b0;
    unique case (phase_r)
      rfhu_pkg::PH_SECOND: hit_valid = word_take;
      default:             hit_valid = 1'b0;
    endcase
  end

  always_comb begin
    hit.module_id      = frame_module_r;
    hit.cable_id       = frame_cable_r;
    hit.converter_addr = held_word_r[31:27];
    hit.channel        = held_word_r[26:22];
    hit.cal_bits       = held_word_r[21:18];
    hit.clock_count    = ~held_word_r[17:12];
    hit.time_value     = ~held_word_r[11:0];
    hit.charge_value   = data_word[11:0];
    hit_index          = hit_cnt_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/readout_frame_hit_unpacker.sv =====
// a word that completes a pair shows its hit on out_* in the cycle after its acceptance
// throughput: one readout word per cycle while in_stall is low, set by the single result register
// in_stall is high only while a result is held and out_stall is high
// reset (rst_n low, synchronous) returns the parser to header, clears the hit index
// and empties the result register
`default_nettype none

module readout_frame_hit_unpacker #(
  parameter int unsigned HIT_INDEX_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [rfhu_pkg::WORD_BITS-1:0]      in_data_word,
  input  wire logic                                in_buffer_end,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [rfhu_pkg::MODULE_BITS-1:0]    out_module_id,
  output      logic [rfhu_pkg::CABLE_BITS-1:0]     out_cable_id,
  output      logic [rfhu_pkg::ADDR_BITS-1:0]      out_converter_addr,
  output      logic [rfhu_pkg::CHAN_BITS-1:0]      out_channel,
  output      logic [rfhu_pkg::CAL_BITS-1:0]       out_cal_bits,
  output      logic [rfhu_pkg::CLOCK_BITS-1:0]     out_clock_count,
  output      logic [rfhu_pkg::TIME_BITS-1:0]      out_time_value,
  output      logic [rfhu_pkg::CHARGE_BITS-1:0]    out_charge_value,
  output      logic [HIT_INDEX_BITS-1:0]           out_hit_index
);

  logic                      res_load;
  logic                      word_take;
  logic                      hit_valid;
  rfhu_pkg::hit_t            hit;
  logic [HIT_INDEX_BITS-1:0] hit_index;
  logic                      out_valid_r, out_valid_nxt;
  rfhu_pkg::hit_t            res_r;
  logic [HIT_INDEX_BITS-1:0] res_index_r;

  // result register is free when empty or being taken this cycle
  assign res_load  = !out_valid_r || !out_stall;
  assign in_stall  = !res_load;
  assign word_take = in_valid && res_load;

  rfhu_parser #(
    .HIT_INDEX_BITS (HIT_INDEX_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_take  (word_take),
    .data_word  (in_data_word),
    .buffer_end (in_buffer_end),
    .hit_valid  (hit_valid),
    .hit        (hit),
    .hit_index  (hit_index)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && hit_valid) begin
      res_r       <= hit;
      res_index_r <= hit_index;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_module_id      = res_r.module_id;
  assign out_cable_id       = res_r.cable_id;
  assign out_converter_addr = res_r.converter_addr;
  assign out_channel        = res_r.channel;
  assign out_cal_bits       = res_r.cal_bits;
  assign out_clock_count    = res_r.clock_count;
  assign out_time_value     = res_r.time_value;
  assign out_charge_value   = res_r.charge_value;
  assign out_hit_index      = res_index_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rfhu_checker.sv =====
`default_nettype none

module rfhu_checker #(
  parameter int unsigned HIT_INDEX_BITS = 16
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [rfhu_pkg::CHARGE_BITS-1:0]    out_charge_value,
  input wire logic [HIT_INDEX_BITS-1:0]           out_hit_index
);

  // a fresh result only follows an accepted word
  a_result_needs_word: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall)
  ) else $error("result appeared without an accepted word");

  // input is only held off by a pending, stalled result
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)
  ) else $error("input stalled while result register free");

  // a stalled result stays valid and keeps its hit index and charge value
  a_hold_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_hit_index) && $stable(out_charge_value))
  ) else $error("stalled result changed");

  a_reset_empty: assert property (
    @(posedge clk)
    !rst_n |=> !out_valid
  ) else $error("result valid after reset");

endmodule

bind readout_frame_hit_unpacker rfhu_checker #(
  .HIT_INDEX_BITS (HIT_INDEX_BITS)
) u_rfhu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_charge_value (out_charge_value),
  .out_hit_index    (out_hit_index)
);

`default_nettype wire

// ===== sim/readout_frame_hit_unpacker_test.sv =====
`default_nettype none

module readout_frame_hit_unpacker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_BITS = 16;
  localparam int LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    rfhu_pkg::hit_t      f;
    logic [IDX_BITS-1:0] idx;
  } hit_rec_t;

  typedef struct packed {
    logic [rfhu_pkg::WORD_BITS-1:0] word;
    logic                           last;
    logic                           drain;
  } word_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rfhu_pkg::WORD_BITS-1:0] in_data_word = '0;
  logic in_buffer_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rfhu_pkg::MODULE_BITS-1:0] out_module_id;
  logic [rfhu_pkg::CABLE_BITS-1:0] out_cable_id;
  logic [rfhu_pkg::ADDR_BITS-1:0] out_converter_addr;
  logic [rfhu_pkg::CHAN_BITS-1:0] out_channel;
  logic [rfhu_pkg::CAL_BITS-1:0] out_cal_bits;
  logic [rfhu_pkg::CLOCK_BITS-1:0] out_clock_count;
  logic [rfhu_pkg::TIME_BITS-1:0] out_time_value;
  logic [rfhu_pkg::CHARGE_BITS-1:0] out_charge_value;
  logic [IDX_BITS-1:0] out_hit_index;

  readout_frame_hit_unpacker #(
    .HIT_INDEX_BITS(IDX_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_word(in_data_word),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_module_id(out_module_id),
    .out_cable_id(out_cable_id),
    .out_converter_addr(out_converter_addr),
    .out_channel(out_channel),
    .out_cal_bits(out_cal_bits),
    .out_clock_count(out_clock_count),
    .out_time_value(out_time_value),
    .out_charge_value(out_charge_value),
    .out_hit_index(out_hit_index)
  );

  always #5 clk = ~clk;

  word_item_t words_pending[$];
  hit_rec_t hits_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  logic in_fire = 1'b0;

  int cycle_count = 0;
  int words_queued = 0;
  int words_taken = 0;
  int ends_taken = 0;
  int hits_checked = 0;
  int error_count = 0;

  // parser copy kept by the testbench
  rfhu_pkg::phase_t parse_ph = rfhu_pkg::PH_HEADER;
  logic [rfhu_pkg::PAIRS_BITS-1:0] pairs_due = '0;
  logic [rfhu_pkg::MODULE_BITS-1:0] cur_module = '0;
  logic [rfhu_pkg::CABLE_BITS-1:0] cur_cable = '0;
  logic [rfhu_pkg::WORD_BITS-1:0] first_word = '0;
  logic [IDX_BITS-1:0] next_index = '0;

  function automatic void unpack_word(input logic [rfhu_pkg::WORD_BITS-1:0] w,
                                      input logic last);
    logic [rfhu_pkg::COUNT_BITS:0] cnt;
    hit_rec_t h;
    case (parse_ph)
      rfhu_pkg::PH_FIRST: begin
        first_word = w;
        parse_ph = rfhu_pkg::PH_SECOND;
      end
      rfhu_pkg::PH_SECOND: begin
        h.f.module_id      = cur_module;
        h.f.cable_id       = cur_cable;
        h.f.converter_addr = first_word[31:27];
        h.f.channel        = first_word[26:22];
        h.f.cal_bits       = first_word[21:18];
        h.f.clock_count    = 6'd63 - first_word[17:12];
        h.f.time_value     = 12'd4095 - first_word[11:0];
        h.f.charge_value   = w[11:0];
        h.idx              = next_index;
        hits_due.push_back(h);
        if (next_index != '1) next_index = next_index + 1'b1;
        if (pairs_due == '0) begin
          parse_ph = rfhu_pkg::PH_HEADER;
        end else begin
          pairs_due = pairs_due - 1'b1;
          parse_ph = rfhu_pkg::PH_FIRST;
        end
      end
      default: begin
        cnt = {1'b0, w[8:0]};
        cur_module = w[31:28];
        cur_cable = w[27:24];
        if (cnt == '0) begin
          parse_ph = rfhu_pkg::PH_HEADER;
          pairs_due = '0;
        end else begin
          // round up to whole pairs, keep the ones after the current pair
          pairs_due = rfhu_pkg::PAIRS_BITS'(((cnt + 1'b1) >> 1) - 1'b1);
          parse_ph = rfhu_pkg::PH_FIRST;
        end
      end
    endcase
    if (last) begin
      parse_ph = rfhu_pkg::PH_HEADER;
      pairs_due = '0;
      next_index = '0;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at hit %0d: %s", hits_checked, msg);
    error_count++;
  endtask

  // input driver
  always @(negedge clk) begin : feed
    word_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(words_pending[0].drain && hits_due.size() != 0)) begin
        it = words_pending.pop_front();
        in_valid <= 1'b1;
        in_data_word <= it.word;
        in_buffer_end <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold whenever hold_len is set
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: predict on input transactions, check result transactions
  always @(posedge clk) begin : watch
    hit_rec_t h;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        flag_mismatch("hit with nothing pending");
      end else begin
        h = hits_due.pop_front();
        if (out_module_id !== h.f.module_id)
          flag_mismatch($sformatf("module_id %0h want %0h", out_module_id, h.f.module_id));
        if (out_cable_id !== h.f.cable_id)
          flag_mismatch($sformatf("cable_id %0h want %0h", out_cable_id, h.f.cable_id));
        if (out_converter_addr !== h.f.converter_addr)
          flag_mismatch($sformatf("converter_addr %0h want %0h",
                                  out_converter_addr, h.f.converter_addr));
        if (out_channel !== h.f.channel)
          flag_mismatch($sformatf("channel %0h want %0h", out_channel, h.f.channel));
        if (out_cal_bits !== h.f.cal_bits)
          flag_mismatch($sformatf("cal_bits %0h want %0h", out_cal_bits, h.f.cal_bits));
        if (out_clock_count !== h.f.clock_count)
          flag_mismatch($sformatf("clock_count %0h want %0h",
                                  out_clock_count, h.f.clock_count));
        if (out_time_value !== h.f.time_value)
          flag_mismatch($sformatf("time_value %0h want %0h", out_time_value, h.f.time_value));
        if (out_charge_value !== h.f.charge_value)
          flag_mismatch($sformatf("charge_value %0h want %0h",
                                  out_charge_value, h.f.charge_value));
        if (out_hit_index !== h.idx)
          flag_mismatch($sformatf("hit_index %0h want %0h", out_hit_index, h.idx));
      end
      hits_checked++;
    end
    if (rst_n && in_valid && !in_stall) begin
      unpack_word(in_data_word, in_buffer_end);
      words_taken++;
      if (in_buffer_end) ends_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_word(input logic [rfhu_pkg::WORD_BITS-1:0] w, input logic last,
                           input logic drain = 1'b0);
    words_pending.push_back('{w, last, drain});
    words_queued++;
  endtask

  // header plus payload rounded up to pairs; end_at puts the buffer end on
  // that word (0 = header) and drops the rest of the frame
  task automatic push_frame(input int cnt, input int end_at);
    int n_pay;
    n_pay = ((cnt + 1) / 2) * 2;
    push_word({4'($urandom), 4'($urandom), 15'($urandom), 9'(cnt)}, end_at == 0);
    if (end_at == 0) return;
    for (int k = 1; k <= n_pay; k++) begin
      push_word($urandom, end_at == k);
      if (end_at == k) return;
    end
  endtask

  task automatic push_random(input int target);
    int start, cnt, n_pay, end_at, r;
    start = words_queued;
    while (words_queued - start < target) begin
      r = $urandom_range(99);
      if (r < 80) begin
        r = $urandom_range(99);
        if (r < 3) cnt = $urandom_range(511, 13);
        else cnt = $urandom_range(12);
        n_pay = ((cnt + 1) / 2) * 2;
        r = $urandom_range(99);
        if (r < 65) end_at = -1;
        else if (r < 85) end_at = n_pay;
        else end_at = $urandom_range(n_pay);
        push_frame(cnt, end_at);
      end else begin
        // stray word, read as whatever the parser expects next
        push_word($urandom, $urandom_range(3) == 0, $urandom_range(19) == 0);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (words_pending.size() != 0 || in_valid || hits_due.size() != 0);
  endtask

  initial begin
    send_idle_pct = 33;
    recv_stall_pct = 77;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // empty frame with all spare header bits set
    push_word({4'hA, 4'h5, 15'h7fff, 9'd0}, 1'b0);
    // odd count, all-ones payload
    push_word({4'hF, 4'hF, 15'h0, 9'd1}, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    // all-zero payload
    push_word({4'h0, 4'h0, 15'h0, 9'd2}, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    // buffer end on a second word still emits its hit
    push_word({4'h3, 4'hC, 15'h1234, 9'd4}, 1'b0);
    push_word(32'h1234_5678, 1'b0);
    push_word(32'h0000_0abc, 1'b0);
    push_word(32'h8765_4321, 1'b0);
    push_word(32'hffff_f000, 1'b1);
    // sender waits for the pipe to drain; frame cut on a held first word
    push_word({4'h9, 4'h6, 15'h0, 9'd6}, 1'b0, 1'b1);
    push_word(32'haaaa_aaaa, 1'b0);
    push_word(32'h5555_5555, 1'b0);
    push_word(32'hdead_beef, 1'b1);
    // buffer end on the header itself
    push_word({4'h7, 4'h1, 15'h0, 9'd3}, 1'b1);
    push_word({4'h1, 4'h2, 15'h5555, 9'd1}, 1'b0);
    push_word(32'h0f0f_0f0f, 1'b0);
    push_word(32'hf0f0_f0f0, 1'b0);
    push_word({4'h0, 4'h0, 15'h0, 9'd0}, 1'b1);
    push_random(300);
    wait_idle();

    @(posedge clk);
    send_idle_pct = 77;
    recv_stall_pct = 33;
    push_random(320);
    wait_idle();

    // no idling, but the receiver first holds off long enough to back up the input
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random(320);
    hold_len = HOLD_CYCLES;
    wait_idle();

    repeat (8) @(posedge clk);
    $display("ran %0d readout words with %0d buffer ends under three back-pressure mixes",
             words_taken, ends_taken);
    $display("checked %0d hits, %0d mismatches", hits_checked, error_count);
    if (error_count == 0 && hits_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/rfhu_pkg.sv
hw/rtl/rfhu_parser.sv
hw/rtl/readout_frame_hit_unpacker.sv
hw/rtl/rfhu_checker.sv
sim/readout_frame_hit_unpacker_test.sv
